// ===== design/lfsp_pkg.sv =====
// lfsp_pkg: shared types, constants and helper functions for the laser frame stream parser
// no dependencies; used by design/laser_frame_stream_parser.sv
`default_nettype none

package lfsp_pkg;

	typedef enum logic [1:0] {
		MODE_SEARCH,
		MODE_HEADER,
		MODE_DATA
	} mode_t;

	localparam int PaletteEntries = 256;

	// section format codes
	localparam logic [7:0] FMT_3D_IDX  = 8'd0;
	localparam logic [7:0] FMT_2D_IDX  = 8'd1;
	localparam logic [7:0] FMT_PALETTE = 8'd2;
	localparam logic [7:0] FMT_3D_TC   = 8'd4;
	localparam logic [7:0] FMT_2D_TC   = 8'd5;

	// header byte positions
	localparam logic [4:0] HDR_FORMAT   = 5'd7;
	localparam logic [4:0] HDR_COUNT_HI = 5'd24;
	localparam logic [4:0] HDR_COUNT_LO = 5'd25;
	localparam logic [4:0] HDR_LAST     = 5'd31;

	localparam logic [2:0] SIG_LAST = 3'd6;

	// record bytes kept in registers; the final byte of a record is used straight off the port
	localparam int RecStore = 9;

	localparam int StatusBlankBit = 6;
	localparam int StatusLastBit  = 7;

	function automatic logic [7:0] sig_byte(input logic [2:0] k);
		logic [7:0] b;
		case (k)
			3'd0:    b = 8'h49;
			3'd1:    b = 8'h4C;
			3'd2:    b = 8'h44;
			3'd3:    b = 8'h41;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [3:0] rec_len(input logic [7:0] fmt);
		logic [3:0] n;
		case (fmt)
			FMT_3D_IDX:  n = 4'd8;
			FMT_2D_IDX:  n = 4'd6;
			FMT_PALETTE: n = 4'd3;
			FMT_3D_TC:   n = 4'd10;
			FMT_2D_TC:   n = 4'd8;
			default:     n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== design/laser_frame_stream_parser.sv =====
// laser frame stream parser: byte-wide section parser with palette memory and point output
// depends on lfsp_pkg
// pipeline: a point's final byte is registered into stage 1, then into the output register
// throughput: one byte per cycle while the output is not stalled; set by the single palette port
//   (write on palette records, registered read on the final byte of every point record)
// reset: parser returns to the signature search; palette valid flags clear at once,
//   so the palette reads as zero with no clearing pass
`default_nettype none

module laser_frame_stream_parser #(
	parameter int PALETTE_ENTRIES = lfsp_pkg::PaletteEntries
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      x_pos,
	output logic signed [15:0]      y_pos,
	output logic signed [15:0]      z_pos,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue,
	output logic                    blanked,
	output logic                    last_point
);

	localparam int AW = $clog2(PALETTE_ENTRIES);

	// parser state
	lfsp_pkg::mode_t mode_q, mode_d;
	logic [4:0]  hdr_idx_q, hdr_idx_d;
	logic [7:0]  fmt_q, fmt_d;
	logic [15:0] cnt_q, cnt_d;
	logic [3:0]  rec_idx_q, rec_idx_d;
	logic [7:0]  pwi_q, pwi_d;
	logic [7:0]  rec_q [lfsp_pkg::RecStore];

	// palette memory and its valid flags
	logic [23:0]                pal_mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] pal_vld_q;

	logic        in_fire;
	logic [3:0]  len;
	logic        in_rec;
	logic        last_byte;
	logic        rec_done;
	logic        pal_wr;
	logic        point;
	logic [2:0]  sig_k;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	// point fields assembled from the stored bytes and the final byte
	logic        three_d;
	logic        indexed;
	logic [7:0]  status;
	logic [23:0] tc_rgb;
	logic [15:0] z_word;

	// stage 1
	logic               s1_valid_q;
	logic [15:0]        x_s1, y_s1, z_s1;
	logic [23:0]        tc_s1;
	logic [23:0]        pal_rd_s1;
	logic               pal_vld_s1;
	logic               idx_ok_s1;
	logic               indexed_s1;
	logic               blank_s1;
	logic               last_s1;
	logic               s1_adv;
	logic [23:0]        col_s1;

	// output register
	logic               out_valid_q;
	logic [15:0]        x_q, y_q, z_q;
	logic [23:0]        rgb_q;
	logic               blank_q;
	logic               last_q;

	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_fire  = in_valid && in_ready;

	assign len       = lfsp_pkg::rec_len(fmt_q);
	assign in_rec    = (mode_q == lfsp_pkg::MODE_DATA) && (rec_idx_q < len);
	assign last_byte = in_rec && (rec_idx_q == len - 4'd1);
	assign rec_done  = in_fire && last_byte;
	assign pal_wr    = rec_done && (fmt_q == lfsp_pkg::FMT_PALETTE)
		&& ({1'b0, pwi_q} < 9'(PALETTE_ENTRIES));
	assign point     = rec_done && (fmt_q != lfsp_pkg::FMT_PALETTE);
	assign wr_addr   = pwi_q[AW-1:0];
	assign rd_addr   = data_byte[AW-1:0];

	assign sig_k = (hdr_idx_q >= 5'd7) ? 3'd0 : hdr_idx_q[2:0];

	always_comb begin
		mode_d    = mode_q;
		hdr_idx_d = hdr_idx_q;
		fmt_d     = fmt_q;
		cnt_d     = cnt_q;
		rec_idx_d = rec_idx_q;
		pwi_d     = pwi_q;
		if (in_fire) begin
			unique case (mode_q)
				lfsp_pkg::MODE_HEADER: begin
					if (hdr_idx_q == lfsp_pkg::HDR_FORMAT) begin
						fmt_d = data_byte;
					end
					if (hdr_idx_q == lfsp_pkg::HDR_COUNT_HI) begin
						cnt_d[15:8] = data_byte;
					end
					if (hdr_idx_q == lfsp_pkg::HDR_COUNT_LO) begin
						cnt_d[7:0] = data_byte;
					end
					if (hdr_idx_q == lfsp_pkg::HDR_LAST) begin
						hdr_idx_d = 5'd0;
						rec_idx_d = 4'd0;
						if (len == 4'd0 || cnt_q == 16'd0) begin
							mode_d = lfsp_pkg::MODE_SEARCH;
						end else begin
							mode_d = lfsp_pkg::MODE_DATA;
							if (fmt_q == lfsp_pkg::FMT_PALETTE) begin
								pwi_d = 8'd0;
							end
						end
					end else begin
						hdr_idx_d = hdr_idx_q + 5'd1;
					end
				end
				lfsp_pkg::MODE_DATA: begin
					if (!in_rec) begin
						mode_d    = lfsp_pkg::MODE_SEARCH;
						hdr_idx_d = 5'd0;
						rec_idx_d = 4'd0;
					end else if (!last_byte) begin
						rec_idx_d = rec_idx_q + 4'd1;
					end else begin
						rec_idx_d = 4'd0;
						cnt_d     = cnt_q - 16'd1;
						if (cnt_q == 16'd1) begin
							mode_d    = lfsp_pkg::MODE_SEARCH;
							hdr_idx_d = 5'd0;
						end
						if (fmt_q == lfsp_pkg::FMT_PALETTE) begin
							pwi_d = pwi_q + 8'd1;
						end
					end
				end
				default: begin
					mode_d = lfsp_pkg::MODE_SEARCH;
					if (data_byte == lfsp_pkg::sig_byte(sig_k)) begin
						if (sig_k == lfsp_pkg::SIG_LAST) begin
							mode_d    = lfsp_pkg::MODE_HEADER;
							hdr_idx_d = lfsp_pkg::HDR_FORMAT;
						end else begin
							hdr_idx_d = {2'b00, sig_k + 3'd1};
						end
					end else if (data_byte == lfsp_pkg::sig_byte(3'd0)) begin
						hdr_idx_d = 5'd1;
					end else begin
						hdr_idx_d = 5'd0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lfsp_pkg::MODE_SEARCH;
		end else begin
			mode_q <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q <= 5'd0;
			fmt_q     <= 8'd0;
			cnt_q     <= 16'd0;
			rec_idx_q <= 4'd0;
			pwi_q     <= 8'd0;
		end else begin
			hdr_idx_q <= hdr_idx_d;
			fmt_q     <= fmt_d;
			cnt_q     <= cnt_d;
			rec_idx_q <= rec_idx_d;
			pwi_q     <= pwi_d;
		end
	end

	// record byte store; the final byte is used off the port, though records under ten bytes also store it here
	always_ff @(posedge clk) begin
		if (in_fire && in_rec && (rec_idx_q < 4'(lfsp_pkg::RecStore))) begin
			rec_q[rec_idx_q] <= data_byte;
		end
	end

	// point decode on the final byte of a record
	assign three_d = (fmt_q == lfsp_pkg::FMT_3D_IDX) || (fmt_q == lfsp_pkg::FMT_3D_TC);
	assign indexed = (fmt_q == lfsp_pkg::FMT_3D_IDX) || (fmt_q == lfsp_pkg::FMT_2D_IDX);
	assign status  = three_d ? rec_q[6] : rec_q[4];
	assign z_word  = three_d ? {rec_q[4], rec_q[5]} : 16'd0;
	// true colour records end in blue, green, red
	assign tc_rgb  = three_d ? {data_byte, rec_q[8], rec_q[7]}
	                         : {data_byte, rec_q[6], rec_q[5]};

	// palette memory: write on a finished palette record, registered read on an indexed point
	always_ff @(posedge clk) begin
		if (pal_wr) begin
			pal_mem[wr_addr] <= {rec_q[0], rec_q[1], data_byte};
		end
		if (point) begin
			pal_rd_s1 <= pal_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (pal_wr) begin
			pal_vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (point) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (point) begin
			x_s1       <= {rec_q[0], rec_q[1]};
			y_s1       <= {rec_q[2], rec_q[3]};
			z_s1       <= z_word;
			tc_s1      <= tc_rgb;
			indexed_s1 <= indexed;
			idx_ok_s1  <= {1'b0, data_byte} < 9'(PALETTE_ENTRIES);
			pal_vld_s1 <= pal_vld_q[rd_addr];
			blank_s1   <= status[lfsp_pkg::StatusBlankBit];
			last_s1    <= status[lfsp_pkg::StatusLastBit];
		end
	end

	// colour select: palette entry never written, index past the palette, or a blanked point reads as zero
	always_comb begin
		if (indexed_s1) begin
			col_s1 = (idx_ok_s1 && pal_vld_s1) ? pal_rd_s1 : 24'd0;
		end else begin
			col_s1 = tc_s1;
		end
		if (blank_s1) begin
			col_s1 = 24'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			x_q     <= x_s1;
			y_q     <= y_s1;
			z_q     <= z_s1;
			rgb_q   <= col_s1;
			blank_q <= blank_s1;
			last_q  <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign x_pos      = x_q;
	assign y_pos      = y_q;
	assign z_pos      = z_q;
	assign red        = rgb_q[23:16];
	assign green      = rgb_q[15:8];
	assign blue       = rgb_q[7:0];
	assign blanked    = blank_q;
	assign last_point = last_q;

endmodule

`default_nettype wire
